// ===== hw/rtl/compressor_hysteresis_controller_assert.svh =====
// Assertion helpers for the compressor controller.
// Both check on the rising clock edge and stay quiet while reset is active.
`ifndef COMPRESSOR_HYSTERESIS_CONTROLLER_ASSERT_SVH
`define COMPRESSOR_HYSTERESIS_CONTROLLER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define CHC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("chc: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define CHC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("chc: next-cycle check failed");

`endif

// ===== hw/rtl/chc_pkg.sv =====
package chc_pkg;

  // Field widths
  localparam int unsigned DEW_W   = 14;
  localparam int unsigned BAND_W  = 11;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned WDATA_W = 32;

  // Working widths for the threshold compares
  localparam int unsigned CMP_W = 16;  // dew +/- band
  localparam int unsigned SCL_W = 18;  // 5*dew vs 5*target +/- 7*band

  // Register reset values
  localparam logic signed [DEW_W-1:0] TARGET_RST   = 14'sd1800;
  localparam logic [BAND_W-1:0]       BAND_RST     = 11'd50;
  localparam logic [TIME_W-1:0]       COOLDOWN_RST = 32'd600000;
  localparam logic [TIME_W-1:0]       MIN_REST_RST = 32'd180000;
  localparam logic [TIME_W-1:0]       MAX_RUN_RST  = 32'd3600000;

  typedef enum logic [IDX_W-1:0] {
    REG_TARGET   = 3'd0,
    REG_BAND     = 3'd1,
    REG_COOLDOWN = 3'd2,
    REG_MIN_REST = 3'd3,
    REG_MAX_RUN  = 3'd4
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_ON     = 3'd1,
    ACT_OFF    = 3'd2,
    ACT_FS_OFF = 3'd3,
    ACT_FS_ON  = 3'd4
  } action_e;

  typedef struct packed {
    logic [IDX_W-1:0]   reg_index;
    logic [WDATA_W-1:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic signed [DEW_W-1:0] target_dew_point;
    logic [BAND_W-1:0]       hysteresis_band;
    logic [TIME_W-1:0]       cooldown_ms;
    logic [TIME_W-1:0]       min_rest_ms;
    logic [TIME_W-1:0]       max_run_ms;
  } cfg_regs_t;

  typedef struct packed {
    logic signed [DEW_W-1:0] dew_point;
    logic [TIME_W-1:0]       time_ms;
  } in_item_t;

  typedef struct packed {
    action_e action;
    logic    compressor_on;
  } out_item_t;

  typedef struct packed {
    logic              running;
    logic              started;
    logic [TIME_W-1:0] first_time;
    logic [TIME_W-1:0] run_since;
    logic [TIME_W-1:0] rest_since;
  } ctrl_state_t;

endpackage

// ===== hw/rtl/chc_stream_if.sv =====
// Valid/ready channel with a typed payload
interface chc_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/chc_decide.sv =====
// Decision logic for one sample: rule priority on, off, failsafe off, failsafe on
module chc_decide (
  input  chc_pkg::cfg_regs_t   cfg_i,
  input  chc_pkg::ctrl_state_t state_i,
  input  chc_pkg::in_item_t    item_i,
  output chc_pkg::ctrl_state_t state_o,
  output chc_pkg::action_e     action_o
);
  import chc_pkg::*;

  logic [TIME_W-1:0]       now;
  logic [TIME_W-1:0]       first_time;
  logic [TIME_W-1:0]       since_first;
  logic [TIME_W-1:0]       since_rest;
  logic [TIME_W-1:0]       since_run;
  logic                    hyst;
  logic signed [CMP_W-1:0] dew;
  logic signed [CMP_W-1:0] tgt;
  logic signed [CMP_W-1:0] band;
  logic signed [SCL_W-1:0] dew5;
  logic signed [SCL_W-1:0] tgt5;
  logic signed [SCL_W-1:0] band7;
  logic                    rule_on;
  logic                    rule_off;
  logic                    rule_fs_off;
  logic                    rule_fs_on;

  assign now = item_i.time_ms;

  // First sample latches its own time stamp as the cooldown origin
  assign first_time  = state_i.started ? state_i.first_time : now;
  assign since_first = now - first_time;
  assign since_rest  = now - state_i.rest_since;
  assign since_run   = now - state_i.run_since;
  assign hyst        = since_first > cfg_i.cooldown_ms;

  // Sign-extended operands; band zero-extended
  assign dew  = CMP_W'(item_i.dew_point);
  assign tgt  = CMP_W'(cfg_i.target_dew_point);
  assign band = signed'({{(CMP_W-BAND_W){1'b0}}, cfg_i.hysteresis_band});

  // Failsafe thresholds scaled by 5, band by 7 (1.4 band exactly)
  assign dew5  = (SCL_W'(dew) <<< 2) + SCL_W'(dew);
  assign tgt5  = (SCL_W'(tgt) <<< 2) + SCL_W'(tgt);
  assign band7 = (SCL_W'(band) <<< 3) - SCL_W'(band);

  assign rule_on = !state_i.running && (dew > tgt + band) &&
                   ((since_rest > cfg_i.min_rest_ms) || !hyst);
  assign rule_off = state_i.running &&
                    ((hyst && (dew < tgt - band)) || (!hyst && (dew < tgt)) ||
                     (since_run > cfg_i.max_run_ms));
  assign rule_fs_off = !state_i.running && (dew5 < tgt5 - band7);
  assign rule_fs_on  = state_i.running && (dew5 > tgt5 + band7);

  // Next state and action
  always_comb begin
    state_o            = state_i;
    state_o.started    = 1'b1;
    state_o.first_time = first_time;
    action_o           = ACT_NONE;
    if (rule_on) begin
      state_o.running   = 1'b1;
      state_o.run_since = now;
      action_o          = ACT_ON;
    end else if (rule_off) begin
      state_o.running    = 1'b0;
      state_o.rest_since = now;
      action_o           = ACT_OFF;
    end else if (rule_fs_off) begin
      state_o.rest_since = now;
      action_o           = ACT_FS_OFF;
    end else if (rule_fs_on) begin
      state_o.run_since = now;
      action_o          = ACT_FS_ON;
    end
  end

endmodule

// ===== hw/rtl/compressor_hysteresis_controller.sv =====
// Compressor on/off controller with hysteresis and anti-short-cycle timing.
// Takes one dew point sample (hundredths of a degree, signed) with a millisecond
// time stamp per transfer and returns exactly one result per sample: the action
// taken and the compressor state afterwards. One sample can be accepted every
// clock cycle while results are taken as they are offered; a sample goes into
// the input register, then through one pass of decision logic into the result
// register, from which its result is offered. While a result waits to be taken,
// one more sample is accepted into the input register and the input then
// stalls until the result transfers. Configuration writes (target, band,
// cooldown, minimum rest, maximum run) are always accepted and must only be
// issued while no sample is in flight; writes to unused indexes are ignored.
// Time stamp differences wrap modulo 2^32.
`include "compressor_hysteresis_controller_assert.svh"

module compressor_hysteresis_controller (
  input logic          clk_i,
  input logic          rst_ni,
  chc_stream_if.sink   cfg_i,
  chc_stream_if.sink   in_i,
  chc_stream_if.source out_o
);
  import chc_pkg::*;

  cfg_regs_t   cfg_q;
  ctrl_state_t state_q;
  ctrl_state_t state_d;
  action_e     action_d;
  in_item_t    in_q;
  logic        in_valid_q;
  out_item_t   out_q;
  logic        out_valid_q;
  logic        advance;

  // Configuration registers: always ready
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_dew_point <= TARGET_RST;
      cfg_q.hysteresis_band  <= BAND_RST;
      cfg_q.cooldown_ms      <= COOLDOWN_RST;
      cfg_q.min_rest_ms      <= MIN_REST_RST;
      cfg_q.max_run_ms       <= MAX_RUN_RST;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.data.reg_index))
        REG_TARGET:   cfg_q.target_dew_point <= signed'(cfg_i.data.wdata[DEW_W-1:0]);
        REG_BAND:     cfg_q.hysteresis_band  <= cfg_i.data.wdata[BAND_W-1:0];
        REG_COOLDOWN: cfg_q.cooldown_ms      <= cfg_i.data.wdata[TIME_W-1:0];
        REG_MIN_REST: cfg_q.min_rest_ms      <= cfg_i.data.wdata[TIME_W-1:0];
        REG_MAX_RUN:  cfg_q.max_run_ms       <= cfg_i.data.wdata[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: the decision stage fires when a sample waits and the result slot is free or being taken
  assign advance  = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
  end

  chc_decide u_decide (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_q),
    .state_o  (state_d),
    .action_o (action_d)
  );

  // Controller state advances with each decided sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q.action        <= action_d;
      out_q.compressor_on <= state_d.running;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // Checks
  `CHC_ASSERT_NOW(a_result_matches_state, clk_i, rst_ni, out_valid_q, out_q.compressor_on == state_q.running)
  `CHC_ASSERT_NOW(a_turn_on_runs, clk_i, rst_ni, out_valid_q && (out_q.action == ACT_ON), out_q.compressor_on)
  `CHC_ASSERT_NEXT(a_started_sticks, clk_i, rst_ni, state_q.started, state_q.started)
  `CHC_ASSERT_NEXT(a_idle_action_holds_state, clk_i, rst_ni, advance && (action_d == ACT_NONE), state_q.running == $past(state_q.running))

endmodule

// ===== sim/tb_compressor_hysteresis_controller.sv =====
module tb_compressor_hysteresis_controller;
  import chc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int DRAIN_CYCLES = 4;

  logic clk_i = 1'b0;
  logic rst_ni;

  chc_stream_if #(.T(cfg_wr_t))   cfg_ch ();
  chc_stream_if #(.T(in_item_t))  sample_ch ();
  chc_stream_if #(.T(out_item_t)) result_ch ();

  compressor_hysteresis_controller dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_ch),
    .in_i  (sample_ch),
    .out_o (result_ch)
  );

  // Idle/stall knobs, in percent per cycle
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        rx_hold = 1'b0;
  event        rx_hold_start;

  int          fail_count = 0;
  int          cycle_count = 0;
  logic [31:0] clock_ms = '0;

  // Shadow of the controller registers
  logic [DEW_W-1:0]  target_reg   = TARGET_RST;
  logic [BAND_W-1:0] band_reg     = BAND_RST;
  logic [TIME_W-1:0] cooldown_reg = COOLDOWN_RST;
  logic [TIME_W-1:0] min_rest_reg = MIN_REST_RST;
  logic [TIME_W-1:0] max_run_reg  = MAX_RUN_RST;

  // Shadow of the controller state
  logic              comp_running  = 1'b0;
  logic              have_first    = 1'b0;
  logic [TIME_W-1:0] first_ms      = '0;
  logic [TIME_W-1:0] run_start_ms  = '0;
  logic [TIME_W-1:0] rest_start_ms = '0;

  out_item_t expected_actions[$];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Compressor decision for one sample; updates the shadow state
  function automatic out_item_t decide_compressor(input in_item_t s);
    int          dew;
    int          tgt;
    int          band;
    logic [31:0] now;
    logic        past_cooldown;
    out_item_t   r;
    dew = int'($signed(s.dew_point));
    tgt = int'($signed(target_reg));
    band = int'(band_reg);
    now = s.time_ms;
    r.action = ACT_NONE;
    if (!have_first) begin
      have_first = 1'b1;
      first_ms = now;
    end
    past_cooldown = (now - first_ms) > cooldown_reg;
    if (dew > tgt + band && !comp_running &&
        ((now - rest_start_ms) > min_rest_reg || !past_cooldown)) begin
      comp_running = 1'b1;
      run_start_ms = now;
      r.action = ACT_ON;
    end else if (comp_running &&
                 ((past_cooldown && dew < tgt - band) ||
                  (!past_cooldown && dew < tgt) ||
                  (now - run_start_ms) > max_run_reg)) begin
      comp_running = 1'b0;
      rest_start_ms = now;
      r.action = ACT_OFF;
    end else if (!comp_running && 5 * dew < 5 * tgt - 7 * band) begin
      rest_start_ms = now;
      r.action = ACT_FS_OFF;
    end else if (comp_running && 5 * dew > 5 * tgt + 7 * band) begin
      run_start_ms = now;
      r.action = ACT_FS_ON;
    end
    r.compressor_on = comp_running;
    return r;
  endfunction

  // Register write transfers update the shadow registers
  always @(posedge clk_i) begin
    if (rst_ni && cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.data.reg_index)
        REG_TARGET:   target_reg   = cfg_ch.data.wdata[DEW_W-1:0];
        REG_BAND:     band_reg     = cfg_ch.data.wdata[BAND_W-1:0];
        REG_COOLDOWN: cooldown_reg = cfg_ch.data.wdata;
        REG_MIN_REST: min_rest_reg = cfg_ch.data.wdata;
        REG_MAX_RUN:  max_run_reg  = cfg_ch.data.wdata;
        default: ;
      endcase
    end
  end

  // Each sample transfer queues its expected result
  always @(posedge clk_i) begin
    if (rst_ni && sample_ch.valid && sample_ch.ready)
      expected_actions.push_back(decide_compressor(sample_ch.data));
  end

  // Result transfers are checked against the oldest expectation
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t seen;
    if (rst_ni && result_ch.valid && result_ch.ready) begin
      seen = result_ch.data;
      if (expected_actions.size() == 0) begin
        $error("unexpected result: action %0d, compressor_on %0d",
               seen.action, seen.compressor_on);
        fail_count++;
      end else begin
        want = expected_actions.pop_front();
        if (seen.action !== want.action) begin
          $error("action: expected %0d, got %0d", want.action, seen.action);
          fail_count++;
        end
        if (seen.compressor_on !== want.compressor_on) begin
          $error("compressor_on: expected %0d, got %0d",
                 want.compressor_on, seen.compressor_on);
          fail_count++;
        end
      end
    end
  end

  // Result-side backpressure
  always @(posedge clk_i)
    result_ch.ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);

  // Long receiver hold-off, counted here
  always begin
    @(rx_hold_start);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // One sample transfer, with random idle cycles ahead of it
  task automatic send_sample(input logic [DEW_W-1:0] dew, input logic [TIME_W-1:0] ms);
    in_item_t s;
    while ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    s.dew_point = dew;
    s.time_ms = ms;
    sample_ch.valid <= 1'b1;
    sample_ch.data <= s;
    do @(posedge clk_i); while (!sample_ch.ready);
  endtask

  // Sample near the current target, sometimes anywhere; time mostly creeps forward
  task automatic send_random_sample();
    int tgt;
    int band;
    int d;
    tgt = int'($signed(target_reg));
    band = int'(band_reg);
    if ($urandom_range(99) < 85) begin
      d = tgt + int'($urandom_range(6 * band + 40)) - (3 * band + 20);
      if (d > 8191) d = 8191;
      if (d < -8192) d = -8192;
    end else begin
      d = int'($urandom_range(16383)) - 8192;
    end
    if ($urandom_range(99) < 93) clock_ms += $urandom_range(400);
    else clock_ms = $urandom();
    send_sample(DEW_W'(d), clock_ms);
  endtask

  // Stop offering and wait until every expected result has come back;
  // a clock edge first so the last transfer has been queued
  task automatic wait_all_results();
    sample_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_actions.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Write all five registers, then one unused index with random data
  task automatic set_config(input logic [31:0] tgt_w, input logic [31:0] band_w,
                            input logic [31:0] cool_w, input logic [31:0] rest_w,
                            input logic [31:0] run_w);
    logic [IDX_W-1:0] idx[6];
    logic [31:0]      val[6];
    cfg_wr_t          wr;
    idx = '{REG_TARGET, REG_BAND, REG_COOLDOWN, REG_MIN_REST, REG_MAX_RUN,
            REG_MAX_RUN + IDX_W'(1) + IDX_W'($urandom_range(2))};
    val = '{tgt_w, band_w, cool_w, rest_w, run_w, $urandom()};
    for (int i = 0; i < 6; i++) begin
      wr.reg_index = idx[i];
      wr.wdata = val[i];
      cfg_ch.valid <= 1'b1;
      cfg_ch.data <= wr;
      do @(posedge clk_i); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Reset settings: first sample at time zero, every action, exact boundaries
  // (cooldown, min rest, max run, failsafe thresholds) and time stamp wrap
  task automatic test_directed();
    int          dew_seq[26] = '{1800, 1851, 1799, 1900, 1700, -8192, 8191, 8191,
                                 1760, 1900, 1900, 1749, 1900, 1900, 1900, 1730,
                                 1729, 1900, 1870, 1871, 1800, 1851, 1800, 1800,
                                 1900, 1900};
    logic [31:0] ms_seq[26] = '{0, 10, 20, 30, 40, 50, 60, 70,
                                600000, 600001, 780001, 780010, 780011, 960011,
                                4560012, 4560020, 4560030, 4740031, 4740040,
                                4740050, 32'hFFFF_FFFF, 5, 3600005, 3600006,
                                3780006, 3780007};
    foreach (dew_seq[i]) send_sample(DEW_W'(dew_seq[i]), ms_seq[i]);
    clock_ms = ms_seq[25];
    wait_all_results();
  endtask

  // Register extremes, band beyond its nominal range, junk in unused bits
  task automatic test_config_extremes();
    set_config(32'hFFFF_E000, 32'hFFFF_FFFF, '0, '0, '0);
    repeat (10) send_random_sample();
    wait_all_results();
    set_config(32'h0000_1FFF, 32'hFFFF_F800, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF);
    repeat (10) send_random_sample();
    wait_all_results();
    set_config($urandom() & ~32'h3FFF, 32'd2000, clock_ms, 32'd1, 32'd1);
    repeat (10) send_random_sample();
    wait_all_results();
  endtask

  // Random settings with short timers so all rules fire, given idle/stall mix
  task automatic test_random_phase(input int unsigned idle_pct,
                                   input int unsigned stall_pct, input int n);
    int          tgt;
    logic [31:0] band;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    tgt = int'($urandom_range(4000)) - 2000;
    band = ($urandom_range(99) < 80) ? $urandom_range(300) : $urandom_range(2047);
    set_config(($urandom() & ~32'h3FFF) | (32'(tgt) & 32'h3FFF),
               ($urandom() & ~32'h7FF) | band,
               clock_ms + $urandom_range(5000), $urandom_range(600),
               $urandom_range(3000));
    repeat (n) send_random_sample();
    wait_all_results();
  endtask

  // Receiver holds off while samples keep coming, so the input stalls
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    -> rx_hold_start;
    repeat (30) send_random_sample();
    wait_all_results();
  endtask

  initial begin
    sample_ch.valid <= 1'b0;
    sample_ch.data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data <= '0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_config_extremes();
    test_random_phase(0, 0, 125);
    test_random_phase(45, 0, 125);
    test_random_phase(0, 45, 125);
    test_random_phase(31, 31, 125);
    test_backpressure();

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
